// ===== design/segi_pkg.sv =====
`default_nettype none

package segi_pkg;

   // how two segments meet
   typedef enum logic [1:0] {
      HIT_NONE  = 2'd0,
      HIT_POINT = 2'd1,
      HIT_SPAN  = 2'd2
   } hit_type;

endpackage

`default_nettype wire

// ===== design/segi_lane.sv =====
`default_nettype none

// One output coordinate: base + round(fac * mul / den), ties away from zero.
// One multiply stage, one setup stage, then one quotient bit per stage.
module segi_lane #(
   parameter int COORD_BITS = 16
) (
   input  wire logic                            clock,
   input  wire logic                            en,
   input  wire logic signed [2*COORD_BITS+2:0]  fac,
   input  wire logic signed [COORD_BITS:0]      mul,
   input  wire logic signed [COORD_BITS-1:0]    base,
   input  wire logic        [2*COORD_BITS+2:0]  den,
   output logic signed      [COORD_BITS-1:0]    coord
);

   localparam int C   = COORD_BITS;
   localparam int DW  = C + 1;
   localparam int EW  = 2 * C + 3;
   localparam int NW  = EW + DW;
   localparam int XW  = NW + 1;
   localparam int YW  = EW + 1;
   localparam int RW  = YW + 1;
   localparam int QW  = C + 3;
   localparam int LAT = QW + 2;

   logic signed [NW-1:0]  prod_ff;
   logic        [EW-1:0]  den_ff;
   logic signed [C-1:0]   base_ff [LAT];

   logic        [RW-1:0]  rem_ff  [QW+1];
   logic        [QW-1:0]  low_ff  [QW+1];
   logic        [QW-1:0]  quo_ff  [QW+1];
   logic        [YW-1:0]  y_ff    [QW+1];
   logic                  neg_ff  [QW+1];

   logic        [NW-1:0]  mag_in;
   logic        [XW-1:0]  x_in;
   logic signed [QW:0]    q_sgn;
   logic signed [QW:0]    sum;

   // multiply numerator
   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= NW'(fac) * NW'(mul);
         den_ff  <= den;
      end
   end

   // carry base along with the quotient
   always_ff @(posedge clock) begin
      if (en) begin
         base_ff[0] <= base;
         for (int i = 1; i < LAT; i++) begin
            base_ff[i] <= base_ff[i-1];
         end
      end
   end

   // form rounded dividend 2|N| + D and divisor 2D
   always_comb begin
      mag_in = prod_ff[NW-1] ? NW'(-prod_ff) : NW'(prod_ff);
      x_in   = {mag_in, 1'b0} + XW'(den_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= RW'(x_in[XW-1:QW]);
         low_ff[0] <= x_in[QW-1:0];
         quo_ff[0] <= '0;
         y_ff[0]   <= {den_ff, 1'b0};
         neg_ff[0] <= prod_ff[NW-1];
      end
   end

   // restoring division, one quotient bit per stage
   for (genvar k = 0; k < QW; k++) begin : g_step
      logic [RW-1:0] t;
      logic          qb;
      always_comb begin
         t  = {rem_ff[k][RW-2:0], low_ff[k][QW-1]};
         qb = (t >= RW'(y_ff[k]));
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1] <= qb ? (t - RW'(y_ff[k])) : t;
            low_ff[k+1] <= {low_ff[k][QW-2:0], 1'b0};
            quo_ff[k+1] <= {quo_ff[k][QW-2:0], qb};
            y_ff[k+1]   <= y_ff[k];
            neg_ff[k+1] <= neg_ff[k];
         end
      end
   end

   // apply sign and add base
   always_comb begin
      q_sgn = neg_ff[QW] ? -$signed({1'b0, quo_ff[QW]}) : $signed({1'b0, quo_ff[QW]});
      sum   = (QW+1)'(base_ff[LAT-1]) + q_sgn;
      coord = sum[C-1:0];
   end

endmodule

`default_nettype wire

// ===== design/segment_intersection_2d.sv =====
`default_nettype none

// Two-segment intersection in signed fixed point (Q12.4 at 16 bits).
// Request channel: req_valid / req_stall with the two segments' endpoints.
// Response channel: rsp_valid / rsp_stall with rsp_hit_count (0 none,
// 1 point, 2 overlap) and up to two points; unused points read zero.
// Each request gives exactly one response, in request order.
// Pipeline from accept to rsp_valid: four setup stages (differences, products,
// determinants, case select), one multiply stage, one divider setup stage,
// one stage per quotient bit (COORD_BITS + 3 of them) in four parallel
// divider lanes, and the output register.
// Throughput: one request per cycle while no stalled response holds the pipeline.
// A stall on the response side freezes the whole pipeline and raises
// req_stall in the same cycle; nothing is lost or repeated.
// Reset clears all stage valid bits; the block is ready right after.
module segment_intersection_2d #(
   parameter int COORD_BITS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic signed [COORD_BITS-1:0]  req_a_start_x,
   input  wire logic signed [COORD_BITS-1:0]  req_a_start_y,
   input  wire logic signed [COORD_BITS-1:0]  req_a_end_x,
   input  wire logic signed [COORD_BITS-1:0]  req_a_end_y,
   input  wire logic signed [COORD_BITS-1:0]  req_b_start_x,
   input  wire logic signed [COORD_BITS-1:0]  req_b_start_y,
   input  wire logic signed [COORD_BITS-1:0]  req_b_end_x,
   input  wire logic signed [COORD_BITS-1:0]  req_b_end_y,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic             [1:0]             rsp_hit_count,
   output logic signed      [COORD_BITS-1:0]  rsp_first_x,
   output logic signed      [COORD_BITS-1:0]  rsp_first_y,
   output logic signed      [COORD_BITS-1:0]  rsp_second_x,
   output logic signed      [COORD_BITS-1:0]  rsp_second_y
);

   localparam int C   = COORD_BITS;
   localparam int DW  = C + 1;
   localparam int PW  = 2 * DW;
   localparam int EW  = PW + 1;
   localparam int KW  = C + 2;
   localparam int QW  = C + 3;
   localparam int LAT = QW + 2;

   logic en;

   // point p within s0..s1 on x, or on y if the segment is vertical
   function automatic logic in_rng(
      input logic signed [C-1:0] s0x, input logic signed [C-1:0] s0y,
      input logic signed [C-1:0] s1x, input logic signed [C-1:0] s1y,
      input logic signed [C-1:0] px,  input logic signed [C-1:0] py
   );
      logic signed [C-1:0] lo;
      logic signed [C-1:0] hi;
      logic signed [C-1:0] p;
      if (s0x != s1x) begin
         lo = s0x; hi = s1x; p = px;
      end else begin
         lo = s0y; hi = s1y; p = py;
      end
      if (lo > hi) begin
         return (hi <= p) && (p <= lo);
      end
      return (lo <= p) && (p <= hi);
   endfunction

   // advance everything unless the output holds a stalled response
   assign en        = !rsp_valid || !rsp_stall;
   assign req_stall = !en;

   // stage 1: differences, range tests and start-point equality
   logic                  v1_ff;
   logic signed [DW-1:0]  ux1_ff, uy1_ff, vx1_ff, vy1_ff, wx1_ff, wy1_ff;
   logic signed [DW-1:0]  n1x1_ff, n1y1_ff;
   logic signed [C-1:0]   ax1_ff, ay1_ff, bx1_ff, by1_ff;
   logic                  ina1_ff, inb1_ff, eq1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ux1_ff  <= DW'(req_a_end_x) - DW'(req_a_start_x);
         uy1_ff  <= DW'(req_a_end_y) - DW'(req_a_start_y);
         vx1_ff  <= DW'(req_b_end_x) - DW'(req_b_start_x);
         vy1_ff  <= DW'(req_b_end_y) - DW'(req_b_start_y);
         wx1_ff  <= DW'(req_a_start_x) - DW'(req_b_start_x);
         wy1_ff  <= DW'(req_a_start_y) - DW'(req_b_start_y);
         n1x1_ff <= DW'(req_a_end_x) - DW'(req_b_start_x);
         n1y1_ff <= DW'(req_a_end_y) - DW'(req_b_start_y);
         ax1_ff  <= req_a_start_x;
         ay1_ff  <= req_a_start_y;
         bx1_ff  <= req_b_start_x;
         by1_ff  <= req_b_start_y;
         ina1_ff <= in_rng(req_b_start_x, req_b_start_y, req_b_end_x, req_b_end_y,
                           req_a_start_x, req_a_start_y);
         inb1_ff <= in_rng(req_a_start_x, req_a_start_y, req_a_end_x, req_a_end_y,
                           req_b_start_x, req_b_start_y);
         eq1_ff  <= (req_a_start_x == req_b_start_x) && (req_a_start_y == req_b_start_y);
      end
   end

   // stage 2: cross products and degenerate-segment tests
   logic                  v2_ff;
   logic signed [PW-1:0]  p_uxvy_ff, p_uyvx_ff, p_uxwy_ff, p_uywx_ff, p_vxwy_ff, p_vywx_ff;
   logic signed [DW-1:0]  ux2_ff, uy2_ff, vx2_ff, vy2_ff, wx2_ff, wy2_ff;
   logic signed [DW-1:0]  n1x2_ff, n1y2_ff;
   logic signed [C-1:0]   ax2_ff, ay2_ff, bx2_ff, by2_ff;
   logic                  ina2_ff, inb2_ff, eq2_ff, apt2_ff, bpt2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_uxvy_ff <= PW'(ux1_ff) * PW'(vy1_ff);
         p_uyvx_ff <= PW'(uy1_ff) * PW'(vx1_ff);
         p_uxwy_ff <= PW'(ux1_ff) * PW'(wy1_ff);
         p_uywx_ff <= PW'(uy1_ff) * PW'(wx1_ff);
         p_vxwy_ff <= PW'(vx1_ff) * PW'(wy1_ff);
         p_vywx_ff <= PW'(vy1_ff) * PW'(wx1_ff);
         ux2_ff  <= ux1_ff;
         uy2_ff  <= uy1_ff;
         vx2_ff  <= vx1_ff;
         vy2_ff  <= vy1_ff;
         wx2_ff  <= wx1_ff;
         wy2_ff  <= wy1_ff;
         n1x2_ff <= n1x1_ff;
         n1y2_ff <= n1y1_ff;
         ax2_ff  <= ax1_ff;
         ay2_ff  <= ay1_ff;
         bx2_ff  <= bx1_ff;
         by2_ff  <= by1_ff;
         ina2_ff <= ina1_ff;
         inb2_ff <= inb1_ff;
         eq2_ff  <= eq1_ff;
         apt2_ff <= (ux1_ff == '0) && (uy1_ff == '0);
         bpt2_ff <= (vx1_ff == '0) && (vy1_ff == '0);
      end
   end

   // stage 3: determinants, normalized skew parameters, collinear projection
   logic signed [EW-1:0]  dd_c, pu_c, pv_c;
   logic signed [KW-1:0]  cd_c, cn0_c, cn1_c;

   always_comb begin
      dd_c = EW'(p_uxvy_ff) - EW'(p_uyvx_ff);
      pu_c = EW'(p_uxwy_ff) - EW'(p_uywx_ff);
      pv_c = EW'(p_vxwy_ff) - EW'(p_vywx_ff);
      if (vx2_ff != '0) begin
         cd_c  = KW'(vx2_ff);
         cn0_c = KW'(wx2_ff);
         cn1_c = KW'(n1x2_ff);
      end else begin
         cd_c  = KW'(vy2_ff);
         cn0_c = KW'(wy2_ff);
         cn1_c = KW'(n1y2_ff);
      end
      if (cd_c < 0) begin
         cd_c  = -cd_c;
         cn0_c = -cn0_c;
         cn1_c = -cn1_c;
      end
   end

   logic                  v3_ff;
   logic signed [EW-1:0]  ad3_ff, sn3_ff, tn3_ff;
   logic                  ddz3_ff, par3_ff;
   logic signed [KW-1:0]  cd3_ff, cn0_3_ff, cn1_3_ff;
   logic signed [DW-1:0]  ux3_ff, uy3_ff, vx3_ff, vy3_ff;
   logic signed [C-1:0]   ax3_ff, ay3_ff, bx3_ff, by3_ff;
   logic                  ina3_ff, inb3_ff, eq3_ff, apt3_ff, bpt3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ad3_ff   <= dd_c[EW-1] ? -dd_c : dd_c;
         sn3_ff   <= dd_c[EW-1] ? -pv_c : pv_c;
         tn3_ff   <= dd_c[EW-1] ? -pu_c : pu_c;
         ddz3_ff  <= (dd_c == '0);
         par3_ff  <= (pu_c != '0) || (pv_c != '0);
         cd3_ff   <= cd_c;
         cn0_3_ff <= (cn0_c > cn1_c) ? cn1_c : cn0_c;
         cn1_3_ff <= (cn0_c > cn1_c) ? cn0_c : cn1_c;
         ux3_ff   <= ux2_ff;
         uy3_ff   <= uy2_ff;
         vx3_ff   <= vx2_ff;
         vy3_ff   <= vy2_ff;
         ax3_ff   <= ax2_ff;
         ay3_ff   <= ay2_ff;
         bx3_ff   <= bx2_ff;
         by3_ff   <= by2_ff;
         ina3_ff  <= ina2_ff;
         inb3_ff  <= inb2_ff;
         eq3_ff   <= eq2_ff;
         apt3_ff  <= apt2_ff;
         bpt3_ff  <= bpt2_ff;
      end
   end

   // stage 4: pick the case and load the four divider lanes
   logic signed [EW-1:0]  fac_c  [4];
   logic signed [DW-1:0]  mul_c  [4];
   logic signed [C-1:0]   base_c [4];
   logic        [EW-1:0]  den_c;
   segi_pkg::hit_type     cnt_c;
   logic signed [KW-1:0]  n0c_c, n1c_c;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         fac_c[i]  = '0;
         mul_c[i]  = '0;
         base_c[i] = '0;
      end
      den_c = EW'(1);
      cnt_c = segi_pkg::HIT_NONE;
      n0c_c = (cn0_3_ff < 0) ? '0 : cn0_3_ff;
      n1c_c = (cn1_3_ff > cd3_ff) ? cd3_ff : cn1_3_ff;
      if (!ddz3_ff) begin
         if (sn3_ff >= 0 && sn3_ff <= ad3_ff && tn3_ff >= 0 && tn3_ff <= ad3_ff) begin
            cnt_c     = segi_pkg::HIT_POINT;
            den_c     = ad3_ff;
            fac_c[0]  = sn3_ff;
            fac_c[1]  = sn3_ff;
            mul_c[0]  = ux3_ff;
            mul_c[1]  = uy3_ff;
            base_c[0] = ax3_ff;
            base_c[1] = ay3_ff;
         end
      end else if (par3_ff) begin
         cnt_c = segi_pkg::HIT_NONE;
      end else if (apt3_ff && bpt3_ff) begin
         if (eq3_ff) begin
            cnt_c     = segi_pkg::HIT_POINT;
            base_c[0] = ax3_ff;
            base_c[1] = ay3_ff;
         end
      end else if (apt3_ff) begin
         if (ina3_ff) begin
            cnt_c     = segi_pkg::HIT_POINT;
            base_c[0] = ax3_ff;
            base_c[1] = ay3_ff;
         end
      end else if (bpt3_ff) begin
         if (inb3_ff) begin
            cnt_c     = segi_pkg::HIT_POINT;
            base_c[0] = bx3_ff;
            base_c[1] = by3_ff;
         end
      end else if (!(cn0_3_ff > cd3_ff || cn1_3_ff < 0)) begin
         den_c     = EW'(cd3_ff);
         fac_c[0]  = EW'(n0c_c);
         fac_c[1]  = EW'(n0c_c);
         mul_c[0]  = vx3_ff;
         mul_c[1]  = vy3_ff;
         base_c[0] = bx3_ff;
         base_c[1] = by3_ff;
         if (n0c_c == n1c_c) begin
            cnt_c = segi_pkg::HIT_POINT;
         end else begin
            cnt_c     = segi_pkg::HIT_SPAN;
            fac_c[2]  = EW'(n1c_c);
            fac_c[3]  = EW'(n1c_c);
            mul_c[2]  = vx3_ff;
            mul_c[3]  = vy3_ff;
            base_c[2] = bx3_ff;
            base_c[3] = by3_ff;
         end
      end
   end

   logic                  v4_ff;
   logic signed [EW-1:0]  fac4_ff  [4];
   logic signed [DW-1:0]  mul4_ff  [4];
   logic signed [C-1:0]   base4_ff [4];
   logic        [EW-1:0]  den4_ff;
   segi_pkg::hit_type     cnt4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 4; i++) begin
            fac4_ff[i]  <= fac_c[i];
            mul4_ff[i]  <= mul_c[i];
            base4_ff[i] <= base_c[i];
         end
         den4_ff <= den_c;
         cnt4_ff <= cnt_c;
      end
   end

   // divider lanes: first x, first y, second x, second y
   logic signed [C-1:0] coord_c [4];

   for (genvar g = 0; g < 4; g++) begin : g_lane
      segi_lane #(
         .COORD_BITS (COORD_BITS)
      ) u_lane (
         .clock (clock),
         .en    (en),
         .fac   (fac4_ff[g]),
         .mul   (mul4_ff[g]),
         .base  (base4_ff[g]),
         .den   (den4_ff),
         .coord (coord_c[g])
      );
   end

   // carry valid and hit count alongside the lanes
   logic              lv_ff  [LAT];
   segi_pkg::hit_type lc_ff  [LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) begin
            lv_ff[i] <= 1'b0;
         end
      end else if (en) begin
         lv_ff[0] <= v4_ff;
         for (int i = 1; i < LAT; i++) begin
            lv_ff[i] <= lv_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lc_ff[0] <= cnt4_ff;
         for (int i = 1; i < LAT; i++) begin
            lc_ff[i] <= lc_ff[i-1];
         end
      end
   end

   // output register
   logic                 rsp_valid_ff;
   segi_pkg::hit_type    hit_ff;
   logic signed [C-1:0]  fx_ff, fy_ff, sx_ff, sy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= lv_ff[LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hit_ff <= lc_ff[LAT-1];
         fx_ff  <= coord_c[0];
         fy_ff  <= coord_c[1];
         sx_ff  <= coord_c[2];
         sy_ff  <= coord_c[3];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hit_count = hit_ff;
   assign rsp_first_x   = fx_ff;
   assign rsp_first_y   = fy_ff;
   assign rsp_second_x  = sx_ff;
   assign rsp_second_y  = sy_ff;

endmodule

`default_nettype wire
